### src/bb3_pkg.sv
// Shared constants and types for the 3x3 box blur stream.
package bb3_pkg;

  // Default frame limits
  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;

  // Field widths
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned IMG_W_W = 11;
  localparam int unsigned IMG_H_W = 13;
  localparam int unsigned CFG_W   = 13;
  localparam int unsigned CFG_IDX_W = 1;

  // Frame size limits and reset size
  localparam int unsigned MIN_DIM   = 3;
  localparam int unsigned DIM_RESET = 512;

  // Nine-pixel sum and divide-by-nine by reciprocal: floor(sum * 7282 / 2^16)
  // is exact for every sum up to 9 * 255.
  localparam int unsigned SUM_W       = 12;
  localparam int unsigned RECIP_W     = 13;
  localparam int unsigned RECIP_9     = 7282;
  localparam int unsigned RECIP_SHIFT = 16;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_e;

endpackage

### src/bb3_stream_if.sv
// Valid/ready stream interfaces for the pixel input and the blurred result.
interface bb3_pix_if;
  logic                       valid;
  logic                       ready;
  logic [bb3_pkg::PIX_W-1:0]  pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface bb3_res_if #(
  parameter int unsigned ROW_W = $clog2(bb3_pkg::MAX_HEIGHT_DEF),
  parameter int unsigned COL_W = $clog2(bb3_pkg::MAX_WIDTH_DEF)
);
  logic                       valid;
  logic                       ready;
  logic [bb3_pkg::PIX_W-1:0]  blurred_pixel;
  logic [ROW_W-1:0]           out_row;
  logic [COL_W-1:0]           out_column;
  logic                       frame_last;

  modport source (output valid, output blurred_pixel, output out_row, output out_column,
                  output frame_last, input ready);
  modport sink   (input valid, input blurred_pixel, input out_row, input out_column,
                  input frame_last, output ready);
endinterface

### src/bb3_ram.sv
// Generic simple dual-port RAM with registered read data.
module bb3_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/box_blur_3x3_stream.sv
// Top level of the 3x3 box blur (mean) filter over a raster pixel stream.
// Takes one 8-bit pixel per clock in raster order and gives, for each
// interior pixel, floor(sum of its 3x3 neighborhood / 9) with its row and
// column; frame_last marks the final interior result of a frame. A result
// leaves after the pixel below and right of its center is taken: the
// line-store read goes to the read stage, then the nine-pixel sum to the
// output register. Sustained rate is one pixel per clock; the input stalls
// only while the output register holds an untaken result and the next
// result is already waiting behind it. Both line stores share one RAM entry
// per column (one read and one write port), so no clearing pass is needed:
// a result only uses rows and columns of the current frame. Writing either
// size register restarts the frame at row 0, column 0; sizes below 3 act as
// 3 and sizes above the MAX_WIDTH / MAX_HEIGHT parameters act as the limit.
module box_blur_3x3_stream #(
  parameter int unsigned MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bb3_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bb3_pkg::CFG_W-1:0]     cfg_data_i,
  bb3_pix_if.sink                       pix_i,
  bb3_res_if.source                     res_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned PW = bb3_pkg::PIX_W;
  localparam int unsigned SW = bb3_pkg::SUM_W;
  localparam int unsigned PRODW = bb3_pkg::SUM_W + bb3_pkg::RECIP_W;
  localparam int unsigned W_RST = (bb3_pkg::DIM_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                                    : bb3_pkg::DIM_RESET;
  localparam int unsigned H_RST = (bb3_pkg::DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT
                                                                     : bb3_pkg::DIM_RESET;
  localparam logic [CW-1:0] W_M1_RST = CW'(W_RST - 1);
  localparam logic [RW-1:0] H_M1_RST = RW'(H_RST - 1);

  // Frame size, stored as last column / last row index
  logic [CW-1:0] w_m1_q, w_m1_d, w_cfg;
  logic [RW-1:0] h_m1_q, h_m1_d, h_cfg;
  logic [bb3_pkg::IMG_W_W-1:0] wv;
  logic [bb3_pkg::IMG_H_W-1:0] hv;
  logic cfg_hit;

  // Position of the next pixel
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic col_last, row_last;

  // Read stage
  logic          s1_valid_q, s1_valid_d;
  logic [PW-1:0] s1_px_q;
  logic [CW-1:0] s1_col_q;
  logic [RW-1:0] s1_row_q;
  logic          s1_res_q;
  logic          s1_last_q;
  logic          s1_adv;
  logic [PW-1:0] top, mid;
  logic [2*PW-1:0] ram_rdata;

  // Window: entries 0..2 column c-2, entries 3..5 column c-1
  logic [PW-1:0] win_q [6];
  logic [SW-1:0] sum_d;

  // Output register
  logic          out_valid_q, out_valid_d;
  logic [SW-1:0] sum_q;
  logic [RW-1:0] orow_q;
  logic [CW-1:0] ocol_q;
  logic          olast_q;
  logic [PRODW-1:0] prod;

  logic in_fire;

  // Clamp incoming sizes
  always_comb begin
    wv = cfg_data_i[bb3_pkg::IMG_W_W-1:0];
    hv = cfg_data_i[bb3_pkg::IMG_H_W-1:0];
    if (32'(wv) < bb3_pkg::MIN_DIM) begin
      w_cfg = CW'(bb3_pkg::MIN_DIM - 1);
    end else if (32'(wv) > MAX_WIDTH) begin
      w_cfg = CW'(MAX_WIDTH - 1);
    end else begin
      w_cfg = CW'(wv - 1'b1);
    end
    if (32'(hv) < bb3_pkg::MIN_DIM) begin
      h_cfg = RW'(bb3_pkg::MIN_DIM - 1);
    end else if (32'(hv) > MAX_HEIGHT) begin
      h_cfg = RW'(MAX_HEIGHT - 1);
    end else begin
      h_cfg = RW'(hv - 1'b1);
    end
  end

  // Register writes
  always_comb begin
    w_m1_d  = w_m1_q;
    h_m1_d  = h_m1_q;
    cfg_hit = 1'b0;
    if (cfg_we_i) begin
      case (bb3_pkg::cfg_idx_e'(cfg_idx_i))
        bb3_pkg::CFG_IMAGE_WIDTH: begin
          w_m1_d  = w_cfg;
          cfg_hit = 1'b1;
        end
        bb3_pkg::CFG_IMAGE_HEIGHT: begin
          h_m1_d  = h_cfg;
          cfg_hit = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  // Handshake
  assign s1_adv      = s1_valid_q && (!s1_res_q || !out_valid_q || res_o.ready);
  assign pix_i.ready = !s1_valid_q || s1_adv;
  assign in_fire     = pix_i.valid && pix_i.ready;

  // Position counters
  assign col_last = (col_q == w_m1_q);
  assign row_last = (row_q == h_m1_q);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_hit) begin
      col_d = '0;
      row_d = '0;
    end else if (in_fire) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_m1_q <= W_M1_RST;
      h_m1_q <= H_M1_RST;
      col_q  <= '0;
      row_q  <= '0;
    end else begin
      w_m1_q <= w_m1_d;
      h_m1_q <= h_m1_d;
      col_q  <= col_d;
      row_q  <= row_d;
    end
  end

  // Line stores: {upper, middle} per column
  bb3_ram #(
    .WIDTH (2 * PW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i ({mid, s1_px_q}),
    .re_i    (in_fire),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  assign top = ram_rdata[2*PW-1:PW];
  assign mid = ram_rdata[PW-1:0];

  // Read stage control
  assign s1_valid_d = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // Read stage payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_px_q   <= pix_i.pixel_in;
      s1_col_q  <= col_q;
      s1_row_q  <= row_q;
      s1_res_q  <= (32'(row_q) >= 2) && (32'(col_q) >= 2);
      s1_last_q <= row_last && col_last;
    end
  end

  // Nine-pixel sum
  always_comb begin
    sum_d = SW'(top) + SW'(mid) + SW'(s1_px_q);
    for (int i = 0; i < 6; i++) begin
      sum_d = sum_d + SW'(win_q[i]);
    end
  end

  // Window shift
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= top;
      win_q[4] <= mid;
      win_q[5] <= s1_px_q;
    end
  end

  // Output register
  assign out_valid_d = (s1_adv && s1_res_q) ? 1'b1 : (res_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_res_q) begin
      sum_q   <= sum_d;
      orow_q  <= s1_row_q - 1'b1;
      ocol_q  <= s1_col_q - 1'b1;
      olast_q <= s1_last_q;
    end
  end

  // Divide by nine through the reciprocal
  assign prod = PRODW'(sum_q) * PRODW'(bb3_pkg::RECIP_9);

  assign res_o.valid         = out_valid_q;
  assign res_o.blurred_pixel = prod[bb3_pkg::RECIP_SHIFT +: PW];
  assign res_o.out_row       = orow_q;
  assign res_o.out_column    = ocol_q;
  assign res_o.frame_last    = olast_q;

  // Checks
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_i.ready |-> (s1_valid_q && s1_res_q && out_valid_q && !res_o.ready))
    else $error("input stalled without a blocked result");

  a_col_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= w_m1_q)
    else $error("column counter beyond frame width");

  a_no_border: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.out_row != '0 && res_o.out_column != '0))
    else $error("result issued for a border pixel");

  a_last_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.frame_last) |-> (res_o.out_column == w_m1_q - 1'b1))
    else $error("frame end flagged off the last interior column");

endmodule

### tb/box_blur_3x3_stream_tb.sv
// Self-checking testbench for box_blur_3x3_stream: random frames, stalls and a mirror of the filter.
module box_blur_3x3_stream_tb;

  localparam int unsigned LONG_HOLD    = 200;  // long receiver hold-off, in cycles
  localparam int unsigned SETTLE       = 6;    // idle cycles after the last result
  localparam int unsigned RANDOM_PIXELS = 180;
  localparam int unsigned RANDOM_CHUNK  = 60;  // most pixels per random frame setting

  typedef enum int unsigned {
    FILL_RANDOM,
    FILL_EXTREME,
    FILL_WHITE,
    FILL_BLACK
  } fill_e;

  typedef struct packed {
    logic [bb3_pkg::PIX_W-1:0] mean;
    logic [11:0]               row;
    logic [9:0]                col;
    logic                      last;
  } blur_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Sources of every block input, known from time zero
  logic                      cfg_we    = 1'b0;
  bb3_pkg::cfg_idx_e         cfg_idx   = bb3_pkg::CFG_IMAGE_WIDTH;
  logic [bb3_pkg::CFG_W-1:0] cfg_data  = '0;
  logic                      pix_valid = 1'b0;
  logic [bb3_pkg::PIX_W-1:0] pix_data  = '0;
  logic                      res_ready = 1'b0;
  bit                        quiet     = 1'b0;  // no random gaps on either side while set

  bb3_pix_if pix ();
  bb3_res_if res ();

  assign pix.valid    = pix_valid;
  assign pix.pixel_in = pix_data;
  assign res.ready    = res_ready;

  box_blur_3x3_stream u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix_i      (pix),
    .res_o      (res)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Pixels waiting for the driver, and blurred results still owed by the block
  logic [bb3_pkg::PIX_W-1:0] pix_pending[$];
  blur_res_t                 blur_owed[$];

  // Mirror of the filter state
  logic [bb3_pkg::PIX_W-1:0]   line_up2 [bb3_pkg::MAX_WIDTH_DEF];
  logic [bb3_pkg::PIX_W-1:0]   line_up1 [bb3_pkg::MAX_WIDTH_DEF];
  logic [bb3_pkg::PIX_W-1:0]   win_cols [6];
  int unsigned                 col_pos, row_pos;
  logic [bb3_pkg::IMG_W_W-1:0] img_w;
  logic [bb3_pkg::IMG_H_W-1:0] img_h;

  int unsigned mismatches, pixels_in, results_ok, frame_ends;
  int unsigned tx_wait, rx_wait, rx_beats;

  // Mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return $urandom_range(1, 2);
    if (roll < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic void check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  // Pixel driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_valid <= 1'b0;
      pix_data  <= '0;
      tx_wait   <= 0;
    end else if (!pix_valid || pix.ready) begin
      if (tx_wait != 0 && rx_wait == 0) begin
        tx_wait   <= tx_wait - 1;
        pix_valid <= 1'b0;
      end else if (pix_pending.size() != 0) begin
        pix_valid <= 1'b1;
        pix_data  <= pix_pending.pop_front();
        tx_wait   <= (quiet || $urandom_range(0, 3) != 0) ? 0 : gap_len();
      end else begin
        pix_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls plus two long hold-offs while the sender keeps going
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ready <= 1'b0;
      rx_wait   <= 0;
      rx_beats  <= 0;
    end else begin
      if (res.valid && res_ready) rx_beats <= rx_beats + 1;
      if (res.valid && res_ready && (rx_beats == 4 || rx_beats == 40)) begin
        rx_wait   <= LONG_HOLD;
        res_ready <= 1'b0;
      end else if (rx_wait != 0) begin
        rx_wait   <= rx_wait - 1;
        res_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        rx_wait   <= gap_len();
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // Monitor: checks result beats and mirrors register writes and pixel beats
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned w, h, c, r, sum;
    logic [bb3_pkg::PIX_W-1:0] top, mid, px;
    blur_res_t want;
    if (!rst_ni) begin
      for (int i = 0; i < bb3_pkg::MAX_WIDTH_DEF; i++) begin
        line_up2[i] = '0;
        line_up1[i] = '0;
      end
      for (int i = 0; i < 6; i++) win_cols[i] = '0;
      col_pos = 0;
      row_pos = 0;
      img_w   = bb3_pkg::IMG_W_W'(bb3_pkg::DIM_RESET);
      img_h   = bb3_pkg::IMG_H_W'(bb3_pkg::DIM_RESET);
      blur_owed.delete();
      mismatches = 0;
      pixels_in  = 0;
      results_ok = 0;
      frame_ends = 0;
    end else begin
      // result beat against the oldest expectation
      if (res.valid && res_ready) begin
        if (blur_owed.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, got mean %0d row %0d col %0d last %0d",
                   $time, res.blurred_pixel, res.out_row, res.out_column, res.frame_last);
        end else begin
          want = blur_owed.pop_front();
          check_field("blurred_pixel", want.mean, res.blurred_pixel);
          check_field("out_row", want.row, res.out_row);
          check_field("out_column", want.col, res.out_column);
          check_field("frame_last", want.last, res.frame_last);
          results_ok++;
          if (res.frame_last) frame_ends++;
        end
      end

      // register write restarts the frame
      if (cfg_we) begin
        case (cfg_idx)
          bb3_pkg::CFG_IMAGE_WIDTH:  img_w = cfg_data[bb3_pkg::IMG_W_W-1:0];
          bb3_pkg::CFG_IMAGE_HEIGHT: img_h = cfg_data[bb3_pkg::IMG_H_W-1:0];
          default: ;
        endcase
        col_pos = 0;
        row_pos = 0;
      end

      // pixel beat: update line stores and window, predict the blurred value
      if (pix_valid && pix.ready) begin
        pixels_in++;
        w = (img_w < bb3_pkg::MIN_DIM) ? bb3_pkg::MIN_DIM
          : (img_w > bb3_pkg::MAX_WIDTH_DEF) ? bb3_pkg::MAX_WIDTH_DEF : img_w;
        h = (img_h < bb3_pkg::MIN_DIM) ? bb3_pkg::MIN_DIM
          : (img_h > bb3_pkg::MAX_HEIGHT_DEF) ? bb3_pkg::MAX_HEIGHT_DEF : img_h;
        c = (col_pos >= w) ? 0 : col_pos;
        r = (row_pos >= h) ? 0 : row_pos;
        px  = pix_data;
        top = line_up2[c];
        mid = line_up1[c];
        line_up2[c] = mid;
        line_up1[c] = px;
        if (r >= 2 && c >= 2) begin
          sum = 32'(top) + 32'(mid) + 32'(px);
          for (int i = 0; i < 6; i++) sum += 32'(win_cols[i]);
          want.mean = bb3_pkg::PIX_W'(sum / 9);
          want.row  = 12'(r - 1);
          want.col  = 10'(c - 1);
          want.last = (r == h - 1) && (c == w - 1);
          blur_owed.push_back(want);
        end
        for (int i = 0; i < 3; i++) win_cols[i] = win_cols[i + 3];
        win_cols[3] = top;
        win_cols[4] = mid;
        win_cols[5] = px;
        if (c + 1 >= w) begin
          col_pos = 0;
          row_pos = (r + 1 >= h) ? 0 : r + 1;
        end else begin
          col_pos = c + 1;
          row_pos = r;
        end
      end
    end
  end

  task automatic write_reg(bb3_pkg::cfg_idx_e idx, logic [bb3_pkg::CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  task automatic queue_pixels(int unsigned n, fill_e fill);
    for (int unsigned i = 0; i < n; i++) begin
      case (fill)
        FILL_WHITE:   pix_pending.push_back(8'hFF);
        FILL_BLACK:   pix_pending.push_back(8'h00);
        FILL_EXTREME: pix_pending.push_back($urandom_range(0, 1) ? 8'hFF : 8'h00);
        default:      pix_pending.push_back(bb3_pkg::PIX_W'($urandom_range(0, 255)));
      endcase
    end
  endtask

  // Wait until every pixel is taken and every result is back, then let the pipe empty
  task automatic drain();
    while (pix_pending.size() != 0 || pix_valid || blur_owed.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Stimulus
  initial begin
    int unsigned w_req, h_req, w_eff, h_eff, frame, n, random_pixels;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Smallest frame from undersized writes: full white, then full black
    write_reg(bb3_pkg::CFG_IMAGE_WIDTH, 13'd0);
    write_reg(bb3_pkg::CFG_IMAGE_HEIGHT, 13'd1);
    quiet = 1'b1;
    queue_pixels(9, FILL_WHITE);
    queue_pixels(9, FILL_BLACK);
    drain();
    // width bits above the register are dropped: 0x800 reads as 0, acts as 3
    write_reg(bb3_pkg::CFG_IMAGE_WIDTH, 13'h0800);
    write_reg(bb3_pkg::CFG_IMAGE_HEIGHT, 13'd2);
    quiet = 1'b0;
    queue_pixels(7, FILL_EXTREME);
    drain();

    // Widest frame (oversized write clamps to the maximum): one full row and the wrap
    write_reg(bb3_pkg::CFG_IMAGE_WIDTH, 13'h1FFF);
    write_reg(bb3_pkg::CFG_IMAGE_HEIGHT, 13'd3);
    queue_pixels(bb3_pkg::MAX_WIDTH_DEF + 16, FILL_RANDOM);
    drain();

    // Tallest settings: oversized and exact maximum height, partial frames
    write_reg(bb3_pkg::CFG_IMAGE_WIDTH, 13'd3);
    write_reg(bb3_pkg::CFG_IMAGE_HEIGHT, 13'h1FFF);
    queue_pixels(60, FILL_EXTREME);
    drain();
    write_reg(bb3_pkg::CFG_IMAGE_HEIGHT, 13'(bb3_pkg::MAX_HEIGHT_DEF));
    queue_pixels(40, FILL_RANDOM);
    drain();

    // Random frame sizes, content and restarts; whole frames plus a tail, capped at RANDOM_CHUNK pixels
    w_req = 3;
    h_req = bb3_pkg::MAX_HEIGHT_DEF;
    random_pixels = 0;
    while (random_pixels < RANDOM_PIXELS) begin
      case ($urandom_range(0, 3))
        0: w_req = $urandom_range(0, 99) < 85 ? $urandom_range(3, 16) : $urandom_range(0, 40);
        1: h_req = $urandom_range(0, 99) < 85 ? $urandom_range(3, 8)
                 : ($urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(4097, 8191));
        default: begin
          w_req = $urandom_range(0, 99) < 85 ? $urandom_range(3, 16) : $urandom_range(0, 40);
          h_req = $urandom_range(0, 99) < 90 ? $urandom_range(3, 8) : $urandom_range(0, 2);
        end
      endcase
      write_reg(bb3_pkg::CFG_IMAGE_WIDTH, 13'(w_req));
      write_reg(bb3_pkg::CFG_IMAGE_HEIGHT, 13'(h_req));
      w_eff = (w_req < bb3_pkg::MIN_DIM) ? bb3_pkg::MIN_DIM : w_req;
      h_eff = (h_req < bb3_pkg::MIN_DIM) ? bb3_pkg::MIN_DIM
            : (h_req > bb3_pkg::MAX_HEIGHT_DEF) ? bb3_pkg::MAX_HEIGHT_DEF : h_req;
      frame = w_eff * h_eff;
      n = frame * $urandom_range(1, 2) + $urandom_range(0, frame - 1);
      if (n > RANDOM_CHUNK) n = RANDOM_CHUNK;
      quiet = ($urandom_range(0, 4) == 0);
      queue_pixels(n, $urandom_range(0, 3) == 0 ? FILL_EXTREME : FILL_RANDOM);
      random_pixels += n;
      drain();
    end

    $display("Run covered %0d pixels and %0d blurred results with %0d frame ends,",
             pixels_in, results_ok, frame_ends);
    $display("size writes from 0 to beyond the limits, a maximum-width row wrap and random frames.");
    if (mismatches == 0) begin
      $display("box_blur_3x3_stream verification clean");
    end else begin
      $display("box_blur_3x3_stream verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20000000;
    $display("box_blur_3x3_stream verification failed");
    $finish;
  end

endmodule
